[rtl/rau_pkg.sv]
// package for the rational arithmetic unit: payload types, codes, constants
`default_nettype none
package rau_pkg;
    localparam int unsigned WIDTH_DEF = 32;
    localparam int unsigned NUM_W = 32;
    localparam int unsigned DEN_W = 31;
    localparam int unsigned ACC_W = 64;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DIVZ  = 2'd1,
        ST_OVFL  = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic signed [31:0] a_num;
        logic [30:0]       a_den;
        logic signed [31:0] b_num;
        logic [30:0]       b_den;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]       res_den;
        logic [1:0]        status;
    } out_word_t;
endpackage
`default_nettype wire

[rtl/rau_mul.sv]
// bit-serial shift-add multiplier for 32 by 32 bit unsigned magnitudes
`default_nettype none
module rau_mul (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        go,
    input  wire logic [31:0] x,
    input  wire logic [31:0] y,
    output logic             done,
    output logic [63:0]      prod
);
    logic [63:0] acc_reg;
    logic [31:0] y_reg;
    logic [31:0] x_reg;
    logic [5:0]  cnt_reg;
    logic        run_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
            done    <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    run_reg <= 1'b0;
                    done    <= 1'b1;
                end
            end
        end
    end

    // one multiplier bit per cycle, msb first
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            acc_reg <= '0;
            x_reg   <= x;
            y_reg   <= y;
        end
        else if (run_reg)
        begin
            acc_reg <= {acc_reg[62:0], 1'b0} + (y_reg[31] ? {32'd0, x_reg} : 64'd0);
            y_reg   <= {y_reg[30:0], 1'b0};
        end
    end

    assign prod = acc_reg;
endmodule
`default_nettype wire

[rtl/rational_arith_unit.sv]
// top level of the rational arithmetic unit: products, gcd reduction, result check
//
// channel | direction | handshake              | payload
// cmd     | in        | start high, busy low   | in_word   (in_word_t)
// result  | out       | done strobe, one cycle | out_word  (out_word_t)
//
// a word with a zero denominator or a zero divisor goes straight to the result check
// a zero result skips the gcd and the divisions; any other word goes through:
// two or three serial products, a binary gcd over 64-bit magnitudes
// (one shift or subtract per cycle, then a shift back by the common power of two),
// and two restoring divisions of 64 quotient bits each by the gcd.
// busy is high from acceptance until the done cycle; reset clears the state register,
// busy and done; the receiver cannot stall, so done is a single-cycle strobe.
`default_nettype none
module rational_arith_unit #(
    parameter int unsigned WIDTH = rau_pkg::WIDTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire rau_pkg::in_word_t  in_word,
    output logic                    busy,
    output logic                    done,
    output rau_pkg::out_word_t      out_word
);
    typedef enum logic [3:0] {
        S_IDLE, S_M1, S_M1W, S_M2, S_M2W, S_M3, S_M3W, S_SUM,
        S_GCD, S_GSH, S_DIV, S_CHK
    } state_t;

    state_t state_reg;
    rau_pkg::in_word_t in_reg;
    logic        an_neg_reg, bn_neg_reg;
    logic [31:0] an_mag_reg, bn_mag_reg;
    logic [63:0] p1_reg, p2_reg;
    logic [63:0] mn_reg, md_reg;
    logic [63:0] gx_reg, gy_reg;
    logic [6:0]  gk_reg;
    logic        neg_reg;
    logic [63:0] q_reg, rem_reg, dv_reg;
    logic [6:0]  dc_reg;
    logic        dsel_reg;
    logic [63:0] qn_reg;

    logic        mgo;
    logic [31:0] mx, my;
    logic        mdone;
    logic [63:0] mprod;

    rau_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (mgo),
        .x     (mx),
        .y     (my),
        .done  (mdone),
        .prod  (mprod)
    );

    logic [63:0] limit;
    logic [63:0] rsub;
    logic        is_sub;
    logic [63:0] s_pos, s_neg;
    assign limit  = 64'd1 << (WIDTH - 1);
    assign is_sub = (in_reg.cmd == rau_pkg::CMD_SUB);
    assign rsub   = {rem_reg[62:0], q_reg[63]} - dv_reg;
    assign s_pos  = p1_reg;
    assign s_neg  = p2_reg;

    always_comb
    begin
        mgo = 1'b0;
        mx  = an_mag_reg;
        my  = {1'b0, in_reg.b_den};
        unique case (state_reg)
            S_M1:
            begin
                mgo = 1'b1;
                if (in_reg.cmd == rau_pkg::CMD_MUL)
                    my = bn_mag_reg;
            end
            S_M2:
            begin
                mgo = 1'b1;
                mx  = bn_mag_reg;
                my  = {1'b0, in_reg.a_den};
                if (in_reg.cmd == rau_pkg::CMD_MUL)
                    mx = {1'b0, in_reg.b_den};
                else if (in_reg.cmd == rau_pkg::CMD_DIV)
                    mx = bn_mag_reg;
            end
            S_M3:
            begin
                mgo = 1'b1;
                mx  = {1'b0, in_reg.a_den};
                my  = {1'b0, in_reg.b_den};
            end
            default: ;
        endcase
    end

    // signed sum of two magnitude products
    logic        sa, sb;
    logic [64:0] sum_v;
    always_comb
    begin
        sa = an_neg_reg;
        sb = bn_neg_reg ^ is_sub;
        if (sa == sb)
            sum_v = {sa, s_pos + s_neg};
        else if (s_pos >= s_neg)
            sum_v = {sa, s_pos - s_neg};
        else
            sum_v = {sb, s_neg - s_pos};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy      <= 1'b0;
            done      <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start && !busy)
                    begin
                        in_reg     <= in_word;
                        an_neg_reg <= in_word.a_num[31];
                        bn_neg_reg <= in_word.b_num[31];
                        an_mag_reg <= in_word.a_num[31] ? 32'd0 - in_word.a_num : in_word.a_num;
                        bn_mag_reg <= in_word.b_num[31] ? 32'd0 - in_word.b_num : in_word.b_num;
                        busy       <= 1'b1;
                        if (in_word.a_den == '0 || in_word.b_den == '0 ||
                            (in_word.cmd == rau_pkg::CMD_DIV && in_word.b_num == '0))
                        begin
                            out_word <= '{32'sd0, 31'd1, rau_pkg::ST_DIVZ};
                            state_reg <= S_CHK;
                            dsel_reg  <= 1'b1;
                        end
                        else
                        begin
                            dsel_reg  <= 1'b0;
                            state_reg <= S_M1;
                        end
                    end
                end
                S_M1: state_reg <= S_M1W;
                S_M1W:
                    if (mdone)
                    begin
                        p1_reg    <= mprod;
                        state_reg <= S_M2;
                    end
                S_M2: state_reg <= S_M2W;
                S_M2W:
                    if (mdone)
                    begin
                        p2_reg <= mprod;
                        if (in_reg.cmd == rau_pkg::CMD_MUL)
                        begin
                            mn_reg    <= p1_reg;
                            md_reg    <= mprod;
                            neg_reg   <= an_neg_reg ^ bn_neg_reg;
                            state_reg <= S_SUM;
                        end
                        else if (in_reg.cmd == rau_pkg::CMD_DIV)
                        begin
                            mn_reg    <= p1_reg;
                            md_reg    <= {mprod[63:0]};
                            state_reg <= S_M3;
                        end
                        else
                            state_reg <= S_M3;
                    end
                S_M3: state_reg <= S_M3W;
                S_M3W:
                    if (mdone)
                    begin
                        if (in_reg.cmd == rau_pkg::CMD_DIV)
                        begin
                            // rd = a_den * b_num: p2 held a_den * |b_num|
                            mn_reg  <= p1_reg;
                            md_reg  <= p2_reg;
                            neg_reg <= an_neg_reg ^ bn_neg_reg;
                        end
                        else
                        begin
                            mn_reg  <= sum_v[63:0];
                            md_reg  <= mprod;
                            neg_reg <= sum_v[64];
                        end
                        state_reg <= S_SUM;
                    end
                S_SUM:
                begin
                    if (mn_reg == '0)
                    begin
                        out_word  <= '{32'sd0, 31'd1, rau_pkg::ST_OK};
                        dsel_reg  <= 1'b1;
                        state_reg <= S_CHK;
                    end
                    else
                    begin
                        gx_reg    <= mn_reg;
                        gy_reg    <= md_reg;
                        gk_reg    <= '0;
                        state_reg <= S_GCD;
                    end
                end
                S_GCD:
                begin
                    // binary gcd: one shift or subtract per cycle
                    if (gx_reg[0] == 1'b0 && gy_reg[0] == 1'b0)
                    begin
                        gx_reg <= gx_reg >> 1;
                        gy_reg <= gy_reg >> 1;
                        gk_reg <= gk_reg + 7'd1;
                    end
                    else if (gx_reg[0] == 1'b0)
                        gx_reg <= gx_reg >> 1;
                    else if (gy_reg[0] == 1'b0)
                        gy_reg <= gy_reg >> 1;
                    else if (gx_reg == gy_reg)
                        state_reg <= S_GSH;
                    else if (gx_reg > gy_reg)
                        gx_reg <= (gx_reg - gy_reg) >> 1;
                    else
                        gy_reg <= (gy_reg - gx_reg) >> 1;
                end
                S_GSH:
                begin
                    if (gk_reg != '0)
                    begin
                        gx_reg <= gx_reg << 1;
                        gk_reg <= gk_reg - 7'd1;
                    end
                    else
                    begin
                        dv_reg    <= gx_reg;
                        q_reg     <= mn_reg;
                        rem_reg   <= '0;
                        dc_reg    <= '0;
                        dsel_reg  <= 1'b0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    // restoring division, one quotient bit per cycle
                    if (!rsub[63] || rem_reg[63])
                    begin
                        rem_reg <= rsub;
                        q_reg   <= {q_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[62:0], q_reg[63]};
                        q_reg   <= {q_reg[62:0], 1'b0};
                    end
                    dc_reg <= dc_reg + 7'd1;
                    if (dc_reg == 7'd63)
                    begin
                        dc_reg <= '0;
                        if (!dsel_reg)
                        begin
                            qn_reg   <= (!rsub[63] || rem_reg[63]) ? {q_reg[62:0], 1'b1}
                                                                  : {q_reg[62:0], 1'b0};
                            q_reg    <= md_reg;
                            rem_reg  <= '0;
                            dsel_reg <= 1'b1;
                        end
                        else
                        begin
                            md_reg    <= (!rsub[63] || rem_reg[63]) ? {q_reg[62:0], 1'b1}
                                                                   : {q_reg[62:0], 1'b0};
                            dsel_reg  <= 1'b0;
                            state_reg <= S_CHK;
                        end
                    end
                end
                S_CHK:
                begin
                    if (!dsel_reg)
                    begin
                        if (md_reg > limit - 64'd1 ||
                            qn_reg > (neg_reg ? limit : limit - 64'd1))
                            out_word <= '{32'sd0, 31'd1, rau_pkg::ST_OVFL};
                        else
                            out_word <= '{neg_reg ? 32'd0 - qn_reg[31:0] : qn_reg[31:0],
                                          md_reg[30:0], rau_pkg::ST_OK};
                    end
                    done      <= 1'b1;
                    busy      <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("done while busy");
    a_done_prev: assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("done without a word in flight");
    a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> out_word.res_den != '0)
        else $error("zero result denominator");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_word.status != rau_pkg::ST_OK) |-> out_word.res_num == '0)
        else $error("error word with nonzero numerator");
endmodule
`default_nettype wire

[dv/rational_arith_unit_test.sv]
// testbench for the rational arithmetic unit: directed table, random words, fraction predictor
`timescale 1ns / 1ps
module rational_arith_unit_test;
    localparam int unsigned W = 32;
    localparam longint unsigned RUN_LIMIT = 3000000;

    logic clk;
    logic rst_n;
    logic start;
    rau_pkg::in_word_t in_word;
    logic busy;
    logic done;
    rau_pkg::out_word_t out_word;

    rational_arith_unit #(.WIDTH(W)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .in_word(in_word),
        .busy(busy),
        .done(done),
        .out_word(out_word)
    );

    rau_pkg::out_word_t pending_q[$];
    int errors;
    longint unsigned cycles;
    int send_idle_pct;

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic longint unsigned gcd_u(input longint unsigned x, input longint unsigned y);
        longint unsigned t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic rau_pkg::out_word_t reduce_fraction(input rau_pkg::in_word_t w);
        rau_pkg::out_word_t r;
        longint an, ad, bn, bd, rn, rd;
        longint unsigned mn, md, g, lim;
        bit neg;
        r.res_num = '0;
        r.res_den = 31'd1;
        r.status = rau_pkg::ST_DIVZ;
        an = longint'(w.a_num);
        bn = longint'(w.b_num);
        ad = longint'({1'b0, w.a_den});
        bd = longint'({1'b0, w.b_den});
        if (ad == 0 || bd == 0)
            return r;
        case (rau_pkg::cmd_t'(w.cmd))
            rau_pkg::CMD_ADD:
            begin
                rn = an * bd + bn * ad;
                rd = ad * bd;
            end
            rau_pkg::CMD_SUB:
            begin
                rn = an * bd - bn * ad;
                rd = ad * bd;
            end
            rau_pkg::CMD_MUL:
            begin
                rn = an * bn;
                rd = ad * bd;
            end
            default:
            begin
                if (bn == 0)
                    return r;
                rn = an * bd;
                rd = ad * bn;
            end
        endcase
        neg = (rn < 0) ^ (rd < 0);
        mn = rn < 0 ? longint'(0) - rn : rn;
        md = rd < 0 ? longint'(0) - rd : rd;
        r.status = rau_pkg::ST_OK;
        if (mn == 0)
            return r;
        g = gcd_u(mn, md);
        mn = mn / g;
        md = md / g;
        lim = 64'd1 << (W - 1);
        if (md > lim - 1 || mn > (neg ? lim : lim - 1))
        begin
            r.status = rau_pkg::ST_OVFL;
            return r;
        end
        r.res_num = neg ? 32'(0 - mn) : 32'(mn);
        r.res_den = 31'(md);
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && done)
        begin
            if (pending_q.size() == 0)
                report_mismatch("result word with nothing expected", 1, 0);
            else
            begin
                rau_pkg::out_word_t e;
                e = pending_q.pop_front();
                if (out_word.res_num !== e.res_num)
                    report_mismatch("res_num", out_word.res_num, e.res_num);
                if (out_word.res_den !== e.res_den)
                    report_mismatch("res_den", out_word.res_den, e.res_den);
                if (out_word.status !== e.status)
                    report_mismatch("status", out_word.status, e.status);
            end
        end
        if (cycles > RUN_LIMIT)
        begin
            $display("** rational_arith_unit: FAILED **");
            $finish;
        end
    end

    task automatic send_word(input rau_pkg::in_word_t w, input bit typed,
                             input rau_pkg::out_word_t want);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        in_word <= w;
        do
            @(posedge clk);
        while (busy);
        pending_q.push_back(typed ? want : reduce_fraction(w));
    endtask

    function automatic logic [31:0] rand_num();
        case ($urandom_range(5, 0))
            0: return 32'($signed($urandom_range(20, 0)) - 10);
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            3: return 32'($urandom_range(2000, 0)) - 32'd1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] rand_den();
        case ($urandom_range(5, 0))
            0: return 31'($urandom_range(12, 1));
            1: return 31'h7fff_ffff;
            2: return 31'($urandom_range(3000, 1));
            3: return 31'd0;
            default: return 31'($urandom);
        endcase
    endfunction

    typedef struct {
        rau_pkg::in_word_t w;
        bit typed;
        rau_pkg::out_word_t want;
    } row_t;

    row_t rows[$];

    function automatic row_t mk(input rau_pkg::cmd_t c, input logic [31:0] an,
                                input logic [30:0] ad, input logic [31:0] bn,
                                input logic [30:0] bd, input bit typed,
                                input logic [31:0] rn, input logic [30:0] rd,
                                input rau_pkg::status_t s);
        row_t r;
        r.w = '{cmd: c, a_num: an, a_den: ad, b_num: bn, b_den: bd};
        r.typed = typed;
        r.want = '{res_num: rn, res_den: rd, status: s};
        return r;
    endfunction

    initial
    begin
        rau_pkg::in_word_t w;
        rau_pkg::out_word_t none;
        errors = 0;
        cycles = 0;
        send_idle_pct = 0;
        none = '0;
        start = 1'b0;
        in_word = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back(mk(rau_pkg::CMD_ADD, 1, 2, 1, 3, 1, 5, 6, rau_pkg::ST_OK));
        rows.push_back(mk(rau_pkg::CMD_SUB, 1, 2, 1, 2, 1, 0, 1, rau_pkg::ST_OK));
        rows.push_back(mk(rau_pkg::CMD_MUL, -2, 3, 3, 4, 1, -1, 2, rau_pkg::ST_OK));
        rows.push_back(mk(rau_pkg::CMD_DIV, 1, 2, -1, 4, 1, -2, 1, rau_pkg::ST_OK));
        rows.push_back(mk(rau_pkg::CMD_DIV, 5, 7, 0, 3, 1, 0, 1, rau_pkg::ST_DIVZ));
        rows.push_back(mk(rau_pkg::CMD_ADD, 5, 0, 1, 3, 1, 0, 1, rau_pkg::ST_DIVZ));
        rows.push_back(mk(rau_pkg::CMD_MUL, 5, 3, 1, 0, 1, 0, 1, rau_pkg::ST_DIVZ));
        rows.push_back(mk(rau_pkg::CMD_MUL, 32'h8000_0000, 1, -1, 1, 1, 0, 1,
                          rau_pkg::ST_OVFL));
        rows.push_back(mk(rau_pkg::CMD_MUL, 32'h8000_0000, 1, 1, 1, 1, 32'h8000_0000, 1,
                          rau_pkg::ST_OK));
        rows.push_back(mk(rau_pkg::CMD_ADD, 32'h7fff_ffff, 1, 1, 1, 1, 0, 1,
                          rau_pkg::ST_OVFL));
        rows.push_back(mk(rau_pkg::CMD_SUB, 32'h8000_0000, 1, 1, 1, 1, 0, 1,
                          rau_pkg::ST_OVFL));
        rows.push_back(mk(rau_pkg::CMD_MUL, 1, 31'h7fff_ffff, 1, 2, 1, 0, 1,
                          rau_pkg::ST_OVFL));
        rows.push_back(mk(rau_pkg::CMD_DIV, 32'h8000_0000, 1, 32'h8000_0000, 1, 1, 1, 1,
                          rau_pkg::ST_OK));
        rows.push_back(mk(rau_pkg::CMD_DIV, 3, 1, 32'h8000_0000, 31'h7fff_ffff, 0, 0, 0,
                          rau_pkg::ST_OK));
        rows.push_back(mk(rau_pkg::CMD_ADD, 32'h7fff_ffff, 31'h7fff_ffff, 32'h8000_0000,
                          31'h7fff_fffe, 0, 0, 0, rau_pkg::ST_OK));
        rows.push_back(mk(rau_pkg::CMD_SUB, 32'h7fff_ffff, 31'h7fff_fffe, 32'h7fff_fffe,
                          31'h7fff_ffff, 0, 0, 0, rau_pkg::ST_OK));
        rows.push_back(mk(rau_pkg::CMD_MUL, 32'h7fff_ffff, 31'h7fff_ffff, 32'h7fff_ffff,
                          31'h7fff_ffff, 1, 1, 1, rau_pkg::ST_OK));
        rows.push_back(mk(rau_pkg::CMD_DIV, 32'h5555_5555, 31'h2aaa_aaaa, 32'hffff_ffff,
                          31'h4000_0001, 0, 0, 0, rau_pkg::ST_OK));
        foreach (rows[i])
            send_word(rows[i].w, rows[i].typed, rows[i].want);
        start <= 1'b0;

        // drain before the random part
        wait (pending_q.size() == 0);
        @(posedge clk);

        for (int n = 0; n < 1950; n++)
        begin
            if (n % 400 == 0)
            begin
                case ((n / 400) % 4)
                    0: send_idle_pct = 0;
                    1: send_idle_pct = 85;
                    2: send_idle_pct = 12;
                    default: send_idle_pct = 0;
                endcase
            end
            w.cmd = 2'($urandom_range(3, 0));
            w.a_num = rand_num();
            w.a_den = rand_den();
            w.b_num = rand_num();
            w.b_den = rand_den();
            if ($urandom_range(19, 0) == 0)
                w.b_num = '0;
            send_word(w, 1'b0, none);
        end
        start <= 1'b0;

        wait (pending_q.size() == 0);
        repeat (500) @(posedge clk);
        if (errors == 0)
            $display("** rational_arith_unit: PASSED **");
        else
            $display("** rational_arith_unit: FAILED **");
        $finish;
    end
endmodule
